FILE: src/lsdt_pkg.sv
// lsdt_pkg: shared types, codes and sizes of the section dirty tracker
// used by every tracker module but lsdt_checker; depends on nothing
`timescale 1ns / 1ps

package lsdt_pkg;

  // table size and derived widths
  localparam int SECTIONS = 16;
  localparam int IDX_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CMP_W    = (IDX_W > 4) ? IDX_W : 4;
  localparam int MAX_OUT  = 16;
  localparam int K_W      = $clog2(MAX_OUT + 1);

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SECTIONS - 1);
  localparam logic [K_W-1:0]   MAX_OUT_K = K_W'(MAX_OUT);

  // merge flag codes as they arrive on the port
  localparam logic signed [1:0] MF_CLEAN = 2'sb00;
  localparam logic signed [1:0] MF_DIRTY = 2'sb01;

  // per-section flag, ordered released < clean < dirty
  typedef enum logic [1:0] {
    FLAG_RELEASED = 2'd0,
    FLAG_CLEAN    = 2'd1,
    FLAG_DIRTY    = 2'd2
  } flag_e;

  // operation codes
  typedef enum logic [2:0] {
    OP_BEGIN      = 3'd0,
    OP_END        = 3'd1,
    OP_MARK_DIRTY = 3'd2,
    OP_MERGE      = 3'd3,
    OP_END_ALL    = 3'd4
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // what the shared entry unit reports for one section
  typedef struct packed {
    flag_e new_flag;
    logic  end_dirty;
    logic  report;
    logic  live;
  } unit_res_t;

endpackage

FILE: src/locked_section_dirty_tracker_core.sv
// locked_section_dirty_tracker_core: top level of the section dirty tracker
// instantiates lsdt_table, lsdt_unit and lsdt_seq; depends on lsdt_pkg
`timescale 1ns / 1ps

// Usage
// - command channel: op_i, section_id_i and merge_flag_i are taken at a rising
//   edge with start high and busy low; busy stays high while the transaction runs
// - config: cfg_we_i writes initial_active_sections_i, which reinitializes the
//   flag table at once (leading sections clean, the rest released); write only
//   while busy is low and no result is still due
// - results: each result shows on result_section_o, was_dirty_o, last_o and
//   section_count_o for one cycle with strobe_o high; the receiver cannot stall
// - every transaction sweeps the table through one shared entry unit, one
//   section per cycle with no stall; busy drops in the cycle that shows the
//   final result, so a new command can be taken from that cycle on; the block
//   takes no new command while a transaction runs
// - end_all holds each dirty section report until the sweep finds the next
//   dirty section and shows it in the cycle after that; the final report comes
//   out after the sweep and carries last_o
// - reset releases every section and clears all control state

module locked_section_dirty_tracker_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        op_i,
  input  logic [3:0]        section_id_i,
  input  logic signed [1:0] merge_flag_i,
  input  logic              cfg_we_i,
  input  logic [4:0]        initial_active_sections_i,
  output logic              strobe_o,
  output logic [3:0]        result_section_o,
  output logic              was_dirty_o,
  output logic              last_o,
  output logic [4:0]        section_count_o
);

  logic [lsdt_pkg::IDX_W-1:0] idx;
  logic                       wr_en;
  lsdt_pkg::flag_e            rd_flag;
  lsdt_pkg::op_e              unit_op;
  logic                       match;
  logic signed [1:0]          unit_mf;
  lsdt_pkg::unit_res_t        unit_res;

  // flag storage
  lsdt_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (initial_active_sections_i),
    .idx_i      (idx),
    .wr_en_i    (wr_en),
    .wr_flag_i  (unit_res.new_flag),
    .rd_flag_o  (rd_flag)
  );

  // shared entry unit
  lsdt_unit u_unit (
    .op_i         (unit_op),
    .flag_i       (rd_flag),
    .match_i      (match),
    .merge_flag_i (unit_mf),
    .res_o        (unit_res)
  );

  // sweep sequencer and result registers
  lsdt_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_o           (busy),
    .op_i             (op_i),
    .section_id_i     (section_id_i),
    .merge_flag_i     (merge_flag_i),
    .res_i            (unit_res),
    .idx_o            (idx),
    .wr_en_o          (wr_en),
    .unit_op_o        (unit_op),
    .match_o          (match),
    .merge_flag_o     (unit_mf),
    .strobe_o         (strobe_o),
    .result_section_o (result_section_o),
    .was_dirty_o      (was_dirty_o),
    .last_o           (last_o),
    .section_count_o  (section_count_o)
  );

endmodule

FILE: src/lsdt_table.sv
// lsdt_table: flag register file, one entry read and written per cycle
// bulk reinit on a configuration write; depends on lsdt_pkg
`timescale 1ns / 1ps

module lsdt_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [4:0]                cfg_data_i,
  input  logic [lsdt_pkg::IDX_W-1:0] idx_i,
  input  logic                      wr_en_i,
  input  lsdt_pkg::flag_e           wr_flag_i,
  output lsdt_pkg::flag_e           rd_flag_o
);

  lsdt_pkg::flag_e flags_q [lsdt_pkg::SECTIONS];

  // entry update: reinit on config, else single-entry write from the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lsdt_pkg::SECTIONS; i++) begin
        flags_q[i] <= lsdt_pkg::FLAG_RELEASED;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < lsdt_pkg::SECTIONS; i++) begin
        flags_q[i] <= (i < int'(cfg_data_i)) ? lsdt_pkg::FLAG_CLEAN
                                             : lsdt_pkg::FLAG_RELEASED;
      end
    end else if (wr_en_i) begin
      flags_q[idx_i] <= wr_flag_i;
    end
  end

  assign rd_flag_o = flags_q[idx_i];

endmodule

FILE: src/lsdt_unit.sv
// lsdt_unit: shared per-section unit, applies one operation to one flag
// purely combinational; depends on lsdt_pkg
`timescale 1ns / 1ps

module lsdt_unit (
  input  lsdt_pkg::op_e       op_i,
  input  lsdt_pkg::flag_e     flag_i,
  input  logic                match_i,
  input  logic signed [1:0]   merge_flag_i,
  output lsdt_pkg::unit_res_t res_o
);

  lsdt_pkg::flag_e nf;

  // next flag and per-entry reports
  always_comb begin
    nf              = flag_i;
    res_o.end_dirty = 1'b0;
    res_o.report    = 1'b0;
    unique case (op_i)
      lsdt_pkg::OP_BEGIN: begin
        if (match_i) nf = lsdt_pkg::FLAG_CLEAN;
      end
      lsdt_pkg::OP_END: begin
        if (match_i) begin
          res_o.end_dirty = (flag_i == lsdt_pkg::FLAG_DIRTY);
          nf              = lsdt_pkg::FLAG_RELEASED;
        end
      end
      lsdt_pkg::OP_MARK_DIRTY: begin
        if (flag_i == lsdt_pkg::FLAG_CLEAN) nf = lsdt_pkg::FLAG_DIRTY;
      end
      lsdt_pkg::OP_MERGE: begin
        // only clean or dirty can raise a flag
        if (match_i && merge_flag_i == lsdt_pkg::MF_CLEAN &&
            flag_i == lsdt_pkg::FLAG_RELEASED) begin
          nf = lsdt_pkg::FLAG_CLEAN;
        end else if (match_i && merge_flag_i == lsdt_pkg::MF_DIRTY) begin
          nf = lsdt_pkg::FLAG_DIRTY;
        end
      end
      lsdt_pkg::OP_END_ALL: begin
        res_o.report = (flag_i == lsdt_pkg::FLAG_DIRTY);
        nf           = lsdt_pkg::FLAG_RELEASED;
      end
      default: begin
        nf = flag_i;
      end
    endcase
    res_o.new_flag = nf;
    res_o.live     = (nf != lsdt_pkg::FLAG_RELEASED);
  end

endmodule

FILE: src/lsdt_seq.sv
// lsdt_seq: sequencer that sweeps the table one section per cycle
// holds the transaction, live extent, pending report and result registers; depends on lsdt_pkg
`timescale 1ns / 1ps

module lsdt_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [2:0]                 op_i,
  input  logic [3:0]                 section_id_i,
  input  logic signed [1:0]          merge_flag_i,
  input  lsdt_pkg::unit_res_t        res_i,
  output logic [lsdt_pkg::IDX_W-1:0] idx_o,
  output logic                       wr_en_o,
  output lsdt_pkg::op_e              unit_op_o,
  output logic                       match_o,
  output logic signed [1:0]          merge_flag_o,
  output logic                       strobe_o,
  output logic [3:0]                 result_section_o,
  output logic                       was_dirty_o,
  output logic                       last_o,
  output logic [4:0]                 section_count_o
);

  lsdt_pkg::state_e            state_q, state_d;
  logic [lsdt_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [2:0]                  op_q, op_d;
  logic [3:0]                  sid_q, sid_d;
  logic signed [1:0]           mf_q, mf_d;
  logic [4:0]                  count_q, count_d;
  logic                        dirty_q, dirty_d;
  logic                        pend_v_q, pend_v_d;
  logic [3:0]                  pend_sec_q, pend_sec_d;
  logic [lsdt_pkg::K_W-1:0]    k_q, k_d;
  logic                        out_v_q, out_v_d;
  logic [3:0]                  out_sec_q, out_sec_d;
  logic                        out_dirty_q, out_dirty_d;
  logic                        out_last_q, out_last_d;
  logic [4:0]                  out_cnt_q, out_cnt_d;
  logic                        accept;

  assign accept       = start_i && (state_q == lsdt_pkg::ST_IDLE);
  assign busy_o       = (state_q != lsdt_pkg::ST_IDLE);
  assign idx_o        = idx_q;
  assign wr_en_o      = (state_q == lsdt_pkg::ST_SCAN);
  assign unit_op_o    = lsdt_pkg::op_e'(op_q);
  assign match_o      = (lsdt_pkg::CMP_W'(sid_q) == lsdt_pkg::CMP_W'(idx_q));
  assign merge_flag_o = mf_q;

  // sweep control and result selection
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    op_d        = op_q;
    sid_d       = sid_q;
    mf_d        = mf_q;
    count_d     = count_q;
    dirty_d     = dirty_q;
    pend_v_d    = pend_v_q;
    pend_sec_d  = pend_sec_q;
    k_d         = k_q;
    out_v_d     = 1'b0;
    out_sec_d   = out_sec_q;
    out_dirty_d = out_dirty_q;
    out_last_d  = out_last_q;
    out_cnt_d   = out_cnt_q;
    unique case (state_q)
      lsdt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d  = lsdt_pkg::ST_SCAN;
          idx_d    = '0;
          op_d     = op_i;
          sid_d    = section_id_i;
          mf_d     = merge_flag_i;
          count_d  = '0;
          dirty_d  = 1'b0;
          pend_v_d = 1'b0;
          k_d      = '0;
        end
      end
      lsdt_pkg::ST_SCAN: begin
        if (res_i.live) count_d = 5'({1'b0, idx_q} + 1'b1);
        if (res_i.end_dirty) dirty_d = 1'b1;
        // dirty reports go out one behind so the final one can carry last
        if (res_i.report && k_q < lsdt_pkg::MAX_OUT_K) begin
          if (pend_v_q) begin
            out_v_d     = 1'b1;
            out_sec_d   = pend_sec_q;
            out_dirty_d = 1'b1;
            out_last_d  = 1'b0;
            out_cnt_d   = '0;
          end
          pend_v_d   = 1'b1;
          pend_sec_d = 4'(idx_q);
          k_d        = k_q + 1'b1;
        end
        if (idx_q == lsdt_pkg::LAST_IDX) begin
          state_d = lsdt_pkg::ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      lsdt_pkg::ST_DONE: begin
        out_v_d    = 1'b1;
        out_last_d = 1'b1;
        if (lsdt_pkg::op_e'(op_q) == lsdt_pkg::OP_END_ALL) begin
          out_sec_d   = pend_v_q ? pend_sec_q : 4'd0;
          out_dirty_d = pend_v_q;
          out_cnt_d   = '0;
        end else begin
          out_sec_d   = sid_q;
          out_dirty_d = dirty_q;
          out_cnt_d   = count_q;
        end
        state_d = lsdt_pkg::ST_IDLE;
      end
      default: begin
        state_d = lsdt_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lsdt_pkg::ST_IDLE;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      k_q      <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
      k_q      <= k_d;
      idx_q    <= idx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    sid_q       <= sid_d;
    mf_q        <= mf_d;
    count_q     <= count_d;
    dirty_q     <= dirty_d;
    pend_sec_q  <= pend_sec_d;
    out_sec_q   <= out_sec_d;
    out_dirty_q <= out_dirty_d;
    out_last_q  <= out_last_d;
    out_cnt_q   <= out_cnt_d;
  end

  assign strobe_o         = out_v_q;
  assign result_section_o = out_sec_q;
  assign was_dirty_o      = out_dirty_q;
  assign last_o           = out_last_q;
  assign section_count_o  = out_cnt_q;

endmodule

FILE: src/lsdt_checker.sv
// lsdt_checker: port-level assertions for the section dirty tracker
// bound to locked_section_dirty_tracker_core; no package dependency
`timescale 1ns / 1ps

module lsdt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              strobe_o,
  input logic              was_dirty_o,
  input logic              last_o
);

  // an accepted transaction keeps the block busy and shows no result yet
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !strobe_o)
    else $error("accept not followed by busy");

  // the final result of a transaction frees the block
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> !busy)
    else $error("busy after final result");

  // a result that is not final belongs to a running end_all
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy && was_dirty_o)
    else $error("intermediate result outside a sweep or not dirty");

  // busy only rises on an accepted command
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

endmodule

bind locked_section_dirty_tracker_core lsdt_checker u_lsdt_checker (.*);
